FILE: rtl/led_fade_engine_top_macros.svh
// Assertion macros shared by the fade engine modules.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef LED_FADE_ENGINE_TOP_MACROS_SVH
`define LED_FADE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LFE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define LFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/lfe_pkg.sv
// Package for the LED fade engine: payload types, states, command codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lfe_pkg;
   localparam int LED_COUNT = 32;
   localparam int LED_W = 5;
   localparam int DIV_STEPS = 24;
   localparam logic CMD_SET = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  led_index;
      logic [23:0] color_rgb;
      logic [15:0] fade_time;
      logic [15:0] start_delay;
   } req_type;

   typedef struct packed {
      logic [4:0]  out_led;
      logic [23:0] out_color;
      logic        busy_res;
      logic        immediate;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SET_RD, ST_SET_WR, ST_TK_RD, ST_TK_EVAL, ST_TK_DIV,
      ST_TK_MUL, ST_TK_WR
   } state_type;

   typedef struct packed {
      logic       rd;        // read LED state at led index
      logic       set_wr;    // apply set request
      logic       div_start;
      logic       div_step;
      logic       mul;
      logic       tk_wr;     // write back and emit result
      logic [LED_W-1:0] led;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic active;          // LED needs fraction/blend
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/led_fade_engine_top.sv
// LED fade engine, 32 LEDs.
// Requests: drive req with start high; taken when busy is low.
// cmd set: one result, after the LED state is read and written, last high.
// cmd tick: visits LEDs 0..31 in order, one result per LED, last on LED 31.
//   An LED waiting or idle passes TK_RD, TK_EVAL and TK_WR; a fading LED
//   also passes TK_DIV, where the one-bit-per-cycle restoring divider
//   forms pos*255/len, and then TK_MUL.
// Results appear on rsp with rsp_valid high for one cycle each; the
//   receiver has to take them as they come.
// Reset (synchronous) returns the controller to idle and marks every LED
//   unwritten, so all LEDs read black with no fade; no clearing pass.
// Depends on lfe_pkg, lfe_ctrl, lfe_datapath.
`timescale 1ns / 1ps
`default_nettype none
module led_fade_engine_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lfe_pkg::req_type req_item,
   output logic                  rsp_valid,
   output lfe_pkg::rsp_type      rsp_item
);
   lfe_pkg::cmd_type cmd;
   lfe_pkg::sts_type sts;

   lfe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_item),
      .busy(busy), .cmd(cmd), .sts(sts)
   );

   lfe_datapath u_dp (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req_item), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp(rsp_item)
   );
endmodule
`default_nettype wire

FILE: rtl/lfe_ctrl.sv
// Controller of the fade engine: sequences set requests and tick sweeps.
// Depends on lfe_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "led_fade_engine_top_macros.svh"
module lfe_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire lfe_pkg::req_type req,
   output logic                 busy,
   output lfe_pkg::cmd_type     cmd,
   input  wire lfe_pkg::sts_type sts
);
   lfe_pkg::state_type state_ff, state_in;
   logic [lfe_pkg::LED_W-1:0] led_ff, led_in;
   logic [lfe_pkg::LED_W-1:0] sidx_ff;
   logic last_led;

   assign last_led = (led_ff == lfe_pkg::LED_W'(lfe_pkg::LED_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfe_pkg::ST_IDLE;
         led_ff <= '0;
      end else begin
         state_ff <= state_in;
         led_ff <= led_in;
      end
      if (state_ff == lfe_pkg::ST_IDLE && start) begin
         sidx_ff <= req.led_index;
      end
   end

   always_comb begin
      state_in = state_ff;
      led_in = led_ff;
      case (state_ff)
         lfe_pkg::ST_IDLE: begin
            if (start) begin
               led_in = '0;
               state_in = (req.cmd == lfe_pkg::CMD_TICK) ? lfe_pkg::ST_TK_RD
                                                           : lfe_pkg::ST_SET_RD;
            end
         end
         lfe_pkg::ST_SET_RD: state_in = lfe_pkg::ST_SET_WR;
         lfe_pkg::ST_SET_WR: state_in = lfe_pkg::ST_IDLE;
         lfe_pkg::ST_TK_RD: state_in = lfe_pkg::ST_TK_EVAL;
         lfe_pkg::ST_TK_EVAL: state_in = sts.active ? lfe_pkg::ST_TK_DIV
                                                     : lfe_pkg::ST_TK_WR;
         lfe_pkg::ST_TK_DIV: if (sts.div_done) state_in = lfe_pkg::ST_TK_MUL;
         lfe_pkg::ST_TK_MUL: state_in = lfe_pkg::ST_TK_WR;
         lfe_pkg::ST_TK_WR: begin
            if (last_led) begin
               state_in = lfe_pkg::ST_IDLE;
            end else begin
               led_in = led_ff + 1'b1;
               state_in = lfe_pkg::ST_TK_RD;
            end
         end
         default: state_in = lfe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != lfe_pkg::ST_IDLE);
      cmd.led = (state_ff == lfe_pkg::ST_SET_RD || state_ff == lfe_pkg::ST_SET_WR)
                ? sidx_ff : led_ff;
      cmd.last = last_led;
      case (state_ff)
         lfe_pkg::ST_SET_RD: cmd.rd = 1'b1;
         lfe_pkg::ST_SET_WR: cmd.set_wr = 1'b1;
         lfe_pkg::ST_TK_RD: cmd.rd = 1'b1;
         lfe_pkg::ST_TK_EVAL: cmd.div_start = 1'b1;
         lfe_pkg::ST_TK_DIV: cmd.div_step = 1'b1;
         lfe_pkg::ST_TK_MUL: cmd.mul = 1'b1;
         lfe_pkg::ST_TK_WR: cmd.tk_wr = 1'b1;
         default: ;
      endcase
   end

   `LFE_ASSERT_NEXT(a_set_wr_follows, clock, reset,
      state_ff == lfe_pkg::ST_SET_RD, state_ff == lfe_pkg::ST_SET_WR)
   `LFE_ASSERT_IMP(a_idle_not_busy, clock, reset,
      state_ff == lfe_pkg::ST_IDLE, !busy)
   `LFE_ASSERT_NEXT(a_led_advance, clock, reset,
      state_ff == lfe_pkg::ST_TK_WR && !last_led, led_ff == $past(led_ff) + 1'b1)
endmodule
`default_nettype wire

FILE: rtl/lfe_datapath.sv
// Datapath of the fade engine: per-LED state memories, fraction divider,
// channel blend and result register. Depends on lfe_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "led_fade_engine_top_macros.svh"
module lfe_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire lfe_pkg::req_type req,
   input  wire lfe_pkg::cmd_type cmd,
   output lfe_pkg::sts_type      sts,
   output logic                  rsp_valid,
   output lfe_pkg::rsp_type      rsp
);
   localparam int N = lfe_pkg::LED_COUNT;

   // Per-LED stores; all are read at one address chosen by the controller.
   logic [23:0] now_mem [N];
   logic [23:0] from_mem [N];
   logic [23:0] to_mem [N];
   logic [15:0] len_mem [N];
   logic [15:0] pos_mem [N];
   logic [15:0] wait_mem [N];
   logic [N-1:0] vld_ff;   // entry written since reset; else state reads as zero

   lfe_pkg::req_type req_ff;
   logic [23:0] now_rd_ff, from_rd_ff, to_rd_ff;
   logic [15:0] len_rd_ff, pos_rd_ff, wait_rd_ff;
   logic [23:0] now_v;
   logic [15:0] len_v, pos_v, wait_v;
   logic idx_ok;

   // Divider: quotient of pos*255 by len, restoring, one bit per cycle.
   logic [23:0] num_ff;
   logic [16:0] rem_ff;
   logic [7:0]  quo_ff;
   logic [4:0]  dcnt_ff;
   logic [16:0] rem_sh;
   logic [23:0] blend_ff;
   logic [23:0] blend_c;
   logic [8:0]  f1;

   // Values written back for the addressed LED.
   logic [23:0] wr_now;
   logic [15:0] wr_len, wr_pos, wr_wait;
   logic        wr_en, ft_wr;

   assign idx_ok = (32'(req_ff.led_index) < 32'(N));
   assign now_v  = vld_ff[cmd.led] ? now_rd_ff : '0;
   assign len_v  = vld_ff[cmd.led] ? len_rd_ff : '0;
   assign pos_v  = vld_ff[cmd.led] ? pos_rd_ff : '0;
   assign wait_v = vld_ff[cmd.led] ? wait_rd_ff : '0;

   assign sts.active = (len_v != 16'd0) && (wait_v == 16'd0);
   assign sts.div_done = (dcnt_ff == 5'(lfe_pkg::DIV_STEPS));
   assign rem_sh = {rem_ff[15:0], num_ff[23]};
   assign f1 = {1'b0, quo_ff} + 9'd1;

   assign wr_en = (cmd.set_wr && idx_ok) || cmd.tk_wr;
   assign ft_wr = cmd.set_wr && idx_ok && (req_ff.fade_time != 16'd0);

   function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                             input logic [8:0] f);
      logic [16:0] d;
      begin
         if (b > a) begin
            d = 17'(b - a) * 17'(f);
            blend_chan = a + d[15:8];
         end else begin
            d = 17'(a - b) * 17'(f);
            blend_chan = a - d[15:8];
         end
      end
   endfunction

   always_comb begin
      blend_c[23:16] = blend_chan(from_rd_ff[23:16], to_rd_ff[23:16], f1);
      blend_c[15:8]  = blend_chan(from_rd_ff[15:8], to_rd_ff[15:8], f1);
      blend_c[7:0]   = blend_chan(from_rd_ff[7:0], to_rd_ff[7:0], f1);
   end

   always_comb begin
      wr_now = now_v;
      wr_len = len_v;
      wr_pos = pos_v;
      wr_wait = wait_v;
      if (cmd.set_wr) begin
         if (req_ff.fade_time == 16'd0) begin
            wr_now = req_ff.color_rgb;
            wr_len = '0;
            wr_pos = '0;
            wr_wait = '0;
         end else begin
            wr_len = req_ff.fade_time;
            wr_pos = '0;
            wr_wait = req_ff.start_delay;
         end
      end else if (len_v != 16'd0) begin
         if (wait_v != 16'd0) begin
            wr_wait = wait_v - 16'd1;
         end else begin
            wr_now = blend_ff;
            if (pos_v >= len_v) begin
               wr_len = '0;
               wr_pos = '0;
               wr_wait = '0;
            end else begin
               wr_pos = pos_v + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req;
      if (cmd.rd) begin
         now_rd_ff  <= now_mem[cmd.led];
         from_rd_ff <= from_mem[cmd.led];
         to_rd_ff   <= to_mem[cmd.led];
         len_rd_ff  <= len_mem[cmd.led];
         pos_rd_ff  <= pos_mem[cmd.led];
         wait_rd_ff <= wait_mem[cmd.led];
      end
      if (cmd.div_start) begin
         num_ff <= {pos_v, 8'd0} - 24'(pos_v);
         rem_ff <= '0;
         quo_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step && !sts.div_done) begin
         num_ff <= {num_ff[22:0], 1'b0};
         dcnt_ff <= dcnt_ff + 1'b1;
         if (rem_sh >= {1'b0, len_v}) begin
            rem_ff <= rem_sh - {1'b0, len_v};
            quo_ff <= {quo_ff[6:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[6:0], 1'b0};
         end
      end
      if (cmd.mul) blend_ff <= blend_c;
      if (wr_en) begin
         now_mem[cmd.led]  <= wr_now;
         len_mem[cmd.led]  <= wr_len;
         pos_mem[cmd.led]  <= wr_pos;
         wait_mem[cmd.led] <= wr_wait;
      end
      if (ft_wr) begin
         from_mem[cmd.led] <= now_v;
         to_mem[cmd.led]   <= req_ff.color_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (wr_en) vld_ff[cmd.led] <= 1'b1;
         rsp_valid <= cmd.set_wr || cmd.tk_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_wr || cmd.tk_wr) begin
         rsp.out_led <= cmd.set_wr ? req_ff.led_index : cmd.led;
         rsp.last <= cmd.set_wr ? 1'b1 : cmd.last;
         rsp.immediate <= cmd.set_wr && idx_ok && (req_ff.fade_time == 16'd0);
         rsp.out_color <= (cmd.set_wr && !idx_ok) ? 24'd0 : wr_now;
         rsp.busy_res <= (cmd.tk_wr || idx_ok) && (wr_len != 16'd0);
      end
   end

   `LFE_ASSERT_NEXT(a_rsp_after_wr, clock, reset, cmd.set_wr || cmd.tk_wr, rsp_valid)
   `LFE_ASSERT_IMP(a_single_wr, clock, reset, cmd.set_wr, !cmd.tk_wr)
   `LFE_ASSERT_NEXT(a_set_last, clock, reset, cmd.set_wr, rsp.last)
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the LED fade engine: directed and random set and tick requests.
// Predicts every result in-bench and compares it with rsp_item; depends on lfe_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   lfe_pkg::req_type req_item = '0;
   logic    rsp_valid;
   lfe_pkg::rsp_type rsp_item;

   led_fade_engine_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted LED state.
   logic [23:0] now_col [lfe_pkg::LED_COUNT];
   logic [23:0] from_col [lfe_pkg::LED_COUNT];
   logic [23:0] to_col [lfe_pkg::LED_COUNT];
   int unsigned len_q [lfe_pkg::LED_COUNT];
   int unsigned pos_q [lfe_pkg::LED_COUNT];
   int unsigned wait_q [lfe_pkg::LED_COUNT];

   lfe_pkg::req_type pending_reqs [$];
   lfe_pkg::rsp_type expected_rsps [$];
   int      errors = 0;
   int      send_idle_pct = 24;
   bit      hold_off = 1'b0;

   function automatic logic [7:0] blend8(logic [7:0] a, logic [7:0] b, int unsigned f);
      int unsigned d;
      if (b > a) begin
         d = ((b - a) * (f + 1)) >> 8;
         return a + d[7:0];
      end
      d = ((a - b) * (f + 1)) >> 8;
      return a - d[7:0];
   endfunction

   task automatic predict_request(lfe_pkg::req_type r);
      lfe_pkg::rsp_type p;
      int unsigned f;
      p = '0;
      if (r.cmd == lfe_pkg::CMD_SET) begin
         p.out_led = r.led_index;
         p.last = 1'b1;
         if (r.led_index >= lfe_pkg::LED_COUNT) begin
         end else if (r.fade_time == 0) begin
            len_q[r.led_index] = 0;
            pos_q[r.led_index] = 0;
            wait_q[r.led_index] = 0;
            now_col[r.led_index] = r.color_rgb;
            p.out_color = r.color_rgb;
            p.immediate = 1'b1;
         end else begin
            from_col[r.led_index] = now_col[r.led_index];
            to_col[r.led_index] = r.color_rgb;
            len_q[r.led_index] = r.fade_time;
            pos_q[r.led_index] = 0;
            wait_q[r.led_index] = r.start_delay;
            p.out_color = now_col[r.led_index];
            p.busy_res = 1'b1;
         end
         expected_rsps.push_back(p);
         return;
      end
      for (int i = 0; i < lfe_pkg::LED_COUNT; i++) begin
         if (len_q[i] > 0 && pos_q[i] < len_q[i] + 1) begin
            if (wait_q[i] > 0) begin
               wait_q[i]--;
            end else begin
               f = ((pos_q[i] * 255) / len_q[i]) & 8'hFF;
               now_col[i] = {blend8(from_col[i][23:16], to_col[i][23:16], f),
                             blend8(from_col[i][15:8], to_col[i][15:8], f),
                             blend8(from_col[i][7:0], to_col[i][7:0], f)};
               pos_q[i]++;
               if (pos_q[i] > len_q[i]) begin
                  len_q[i] = 0;
                  pos_q[i] = 0;
                  wait_q[i] = 0;
               end
            end
         end
         p = '0;
         p.out_led = i[4:0];
         p.out_color = now_col[i];
         p.busy_res = (len_q[i] > 0);
         p.last = (i == lfe_pkg::LED_COUNT - 1);
         expected_rsps.push_back(p);
      end
   endtask

   // Driver: holds start high until the request is taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_request(req_item);
         if (pending_reqs.size() > 0 && !hold_off
             && $urandom_range(99) >= send_idle_pct) begin
            req_item <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_reqs.size() > 0 && !hold_off
                   && $urandom_range(99) >= send_idle_pct) begin
         req_item <= pending_reqs.pop_front();
         start <= 1'b1;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      lfe_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result led %0d", rsp_item.out_led);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_item.out_led !== e.out_led) begin
               $error("out_led exp %0d got %0d", e.out_led, rsp_item.out_led);
               errors++;
            end
            if (rsp_item.out_color !== e.out_color) begin
               $error("out_color exp %h got %h", e.out_color, rsp_item.out_color);
               errors++;
            end
            if (rsp_item.busy_res !== e.busy_res) begin
               $error("busy_res exp %b got %b", e.busy_res, rsp_item.busy_res);
               errors++;
            end
            if (rsp_item.immediate !== e.immediate) begin
               $error("immediate exp %b got %b", e.immediate, rsp_item.immediate);
               errors++;
            end
            if (rsp_item.last !== e.last) begin
               $error("last exp %b got %b", e.last, rsp_item.last);
               errors++;
            end
         end
      end
   end

   function automatic lfe_pkg::req_type make_set(int idx, logic [23:0] c, int ft, int sd);
      lfe_pkg::req_type r;
      r = '0;
      r.cmd = lfe_pkg::CMD_SET;
      r.led_index = idx[4:0];
      r.color_rgb = c;
      r.fade_time = ft[15:0];
      r.start_delay = sd[15:0];
      return r;
   endfunction

   function automatic lfe_pkg::req_type make_tick();
      lfe_pkg::req_type r;
      r = '0;
      r.cmd = lfe_pkg::CMD_TICK;
      // Fields other than cmd are ignored on a tick; fill them anyway.
      r.led_index = 5'($urandom);
      r.color_rgb = 24'($urandom);
      r.fade_time = 16'($urandom);
      r.start_delay = 16'($urandom);
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      lfe_pkg::req_type r;
      int      ft;
      for (int i = 0; i < lfe_pkg::LED_COUNT; i++) begin
         now_col[i] = '0; from_col[i] = '0; to_col[i] = '0;
         len_q[i] = 0; pos_q[i] = 0; wait_q[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, immediate and fading sets, delays, fade ends.
      pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_set(0, 24'hFFFFFF, 0, 16'hFFFF));
      pending_reqs.push_back(make_set(31, 24'h00FF00, 0, 0));
      pending_reqs.push_back(make_set(0, 24'h000000, 1, 0));
      pending_reqs.push_back(make_set(31, 24'hFF00FF, 2, 1));
      pending_reqs.push_back(make_set(5, 24'h123456, 65535, 65535));
      pending_reqs.push_back(make_set(7, 24'hA5A5A5, 255, 0));
      for (int k = 0; k < 5; k++) pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_set(5, 24'h000000, 0, 0));
      pending_reqs.push_back(make_set(7, 24'h5A5A5A, 3, 0));
      pending_reqs.push_back(make_set(7, 24'hFFFFFF, 300, 2));
      for (int k = 0; k < 4; k++) pending_reqs.push_back(make_tick());

      // Random part in three idling phases; small fades so many complete.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 61 : 0;
         for (int n = 0; n < 160; n++) begin
            if ($urandom_range(99) < 40) begin
               r = make_tick();
            end else begin
               case ($urandom_range(9))
                  0: ft = 0;
                  1: ft = $urandom_range(65535);
                  2: ft = 65535;
                  default: ft = $urandom_range(1, 6);
               endcase
               r = make_set($urandom_range(31), 24'($urandom),
                            ft, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                         : $urandom_range(3));
            end
            pending_reqs.push_back(r);
            if (ph == 1 && n == 80) begin
               // Wait until the block has drained, then hold the sender off.
               wait_drained();
               hold_off = 1'b1;
               repeat (20) @(posedge clock);
               hold_off = 1'b0;
            end
         end
      end
      wait_drained();
      repeat (1000) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/lfe_pkg.sv
rtl/lfe_ctrl.sv
rtl/lfe_datapath.sv
rtl/led_fade_engine_top.sv
tb/tb_top.sv
